[design/lqrg_pkg.sv]
package lqrg_pkg;

  // datapath word and fixed point scale
  localparam int W      = 48;
  localparam int FRAC   = 24;
  localparam int QW     = W + FRAC;
  localparam int AW     = 7;
  localparam int DEPTH  = 128;
  localparam int NPROG  = 47;
  localparam int PCW    = 6;

  // element slots as loaded, followed by the working area
  localparam logic [AW-1:0] BASE_A    = 7'd0;
  localparam logic [AW-1:0] BASE_B    = 7'd9;
  localparam logic [AW-1:0] BASE_Q    = 7'd15;
  localparam logic [AW-1:0] BASE_R    = 7'd24;
  localparam logic [AW-1:0] BASE_X    = 7'd28;
  localparam logic [AW-1:0] BASE_REF  = 7'd31;
  localparam logic [AW-1:0] SLOT_END  = 7'd34;
  localparam logic [AW-1:0] BASE_P    = 7'd34;
  localparam logic [AW-1:0] BASE_PN   = 7'd43;
  localparam logic [AW-1:0] BASE_PA   = 7'd52;
  localparam logic [AW-1:0] BASE_PB   = 7'd61;
  localparam logic [AW-1:0] BASE_S    = 7'd67;
  localparam logic [AW-1:0] BASE_BPA  = 7'd71;
  localparam logic [AW-1:0] BASE_APA  = 7'd77;
  localparam logic [AW-1:0] BASE_APB  = 7'd86;
  localparam logic [AW-1:0] BASE_T0   = 7'd92;
  localparam logic [AW-1:0] BASE_T1   = 7'd93;
  localparam logic [AW-1:0] BASE_DET  = 7'd94;
  localparam logic [AW-1:0] BASE_ADJ  = 7'd95;
  localparam logic [AW-1:0] BASE_TG   = 7'd99;
  localparam logic [AW-1:0] BASE_G    = 7'd105;
  localparam logic [AW-1:0] BASE_CORR = 7'd111;
  localparam logic [AW-1:0] BASE_U    = 7'd120;
  localparam logic [AW-1:0] ZERO_ADDR = 7'd127;

  localparam logic [PCW-1:0] PC_LOOP = 6'd2;
  localparam logic [PCW-1:0] PC_FIN  = 6'd26;

  typedef logic signed [W-1:0] fx_t;

  typedef enum logic [3:0] {
    OP_MAC, OP_ADD, OP_SUB, OP_DIV, OP_CMP, OP_CHK, OP_NEXT, OP_JMP, OP_DONE
  } op_kind_e;

  typedef enum logic [1:0] {AK_MAC, AK_ADD, AK_SUB, AK_DIV} alu_kind_e;

  typedef struct packed {
    op_kind_e       kind;
    logic [AW-1:0]  a_base;
    logic [1:0]     a_si;
    logic [1:0]     a_sj;
    logic [1:0]     a_sk;
    logic [AW-1:0]  b_base;
    logic [1:0]     b_si;
    logic [1:0]     b_sj;
    logic [1:0]     b_sk;
    logic [AW-1:0]  z_base;
    logic [1:0]     rows;
    logic [1:0]     inner;
    logic [3:0]     cols;
    logic [PCW-1:0] target;
  } op_t;

  typedef struct packed {
    logic      start;
    alu_kind_e kind;
    fx_t       a;
    fx_t       b;
    fx_t       acc;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic dzero;
    fx_t  res;
  } alu_rsp_t;

  localparam fx_t FX_MAX = {1'b0, {(W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(W-1){1'b0}}};

  function automatic fx_t sat_add(fx_t a, fx_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? FX_MIN : FX_MAX;
    return s[W-1:0];
  endfunction

  function automatic fx_t sat_sub(fx_t a, fx_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? FX_MIN : FX_MAX;
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(fx_t a);
    return a[W-1] ? W'(-a) : W'(a);
  endfunction

  // apply sign to a magnitude, saturating to the word range
  function automatic fx_t fin(logic neg, logic [QW:0] m);
    logic [QW:0] cap;
    logic [QW:0] v;
    cap = neg ? (QW+1)'({1'b1, {(W-1){1'b0}}}) : (QW+1)'({1'b0, {(W-1){1'b1}}});
    v   = (m > cap) ? cap : m;
    return neg ? fx_t'(-v[W-1:0]) : fx_t'(v[W-1:0]);
  endfunction

  function automatic op_t mm_op(op_kind_e kind, logic [AW-1:0] a, int asi, int ask,
                                logic [AW-1:0] b, int bsk, int bsj,
                                logic [AW-1:0] z, int rows, int inner, int cols);
    op_t o;
    o        = '0;
    o.kind   = kind;
    o.a_base = a;
    o.a_si   = 2'(asi);
    o.a_sk   = 2'(ask);
    o.b_base = b;
    o.b_sk   = 2'(bsk);
    o.b_sj   = 2'(bsj);
    o.z_base = z;
    o.rows   = 2'(rows);
    o.inner  = 2'(inner);
    o.cols   = 4'(cols);
    return o;
  endfunction

  function automatic op_t ew_op(op_kind_e kind, logic [AW-1:0] a, int asj,
                                logic [AW-1:0] b, int bsj, logic [AW-1:0] z, int len);
    op_t o;
    o        = '0;
    o.kind   = kind;
    o.a_base = a;
    o.a_sj   = 2'(asj);
    o.b_base = b;
    o.b_sj   = 2'(bsj);
    o.z_base = z;
    o.rows   = 2'd1;
    o.inner  = 2'd1;
    o.cols   = 4'(len);
    return o;
  endfunction

  function automatic op_t ctl_op(op_kind_e kind, logic [PCW-1:0] target);
    op_t o;
    o        = '0;
    o.kind   = kind;
    o.target = target;
    return o;
  endfunction

  // solve sequence; the gain terms appear once in the loop and once after it
  localparam op_t PROG [NPROG] = '{
    ew_op(OP_ADD, BASE_Q, 1, ZERO_ADDR, 0, BASE_P, 9),
    ew_op(OP_ADD, BASE_Q, 1, ZERO_ADDR, 0, BASE_PN, 9),
    ctl_op(OP_CHK, PC_FIN),
    mm_op(OP_MAC, BASE_P, 3, 1, BASE_A, 3, 1, BASE_PA, 3, 3, 3),
    mm_op(OP_MAC, BASE_P, 3, 1, BASE_B, 2, 1, BASE_PB, 3, 3, 2),
    mm_op(OP_MAC, BASE_B, 1, 2, BASE_PB, 2, 1, BASE_S, 2, 3, 2),
    ew_op(OP_ADD, BASE_R, 1, BASE_S, 1, BASE_S, 4),
    mm_op(OP_MAC, BASE_B, 1, 2, BASE_PA, 3, 1, BASE_BPA, 2, 3, 3),
    mm_op(OP_MAC, BASE_A, 1, 3, BASE_PA, 3, 1, BASE_APA, 3, 3, 3),
    mm_op(OP_MAC, BASE_A, 1, 3, BASE_PB, 2, 1, BASE_APB, 3, 3, 2),
    mm_op(OP_MAC, BASE_S, 0, 0, BASE_S + 7'd3, 0, 0, BASE_T0, 1, 1, 1),
    mm_op(OP_MAC, BASE_S + 7'd1, 0, 0, BASE_S + 7'd2, 0, 0, BASE_T1, 1, 1, 1),
    ew_op(OP_SUB, BASE_T0, 0, BASE_T1, 0, BASE_DET, 1),
    ew_op(OP_ADD, BASE_S + 7'd3, 0, ZERO_ADDR, 0, BASE_ADJ, 1),
    ew_op(OP_SUB, ZERO_ADDR, 0, BASE_S + 7'd1, 0, BASE_ADJ + 7'd1, 1),
    ew_op(OP_SUB, ZERO_ADDR, 0, BASE_S + 7'd2, 0, BASE_ADJ + 7'd2, 1),
    ew_op(OP_ADD, BASE_S, 0, ZERO_ADDR, 0, BASE_ADJ + 7'd3, 1),
    mm_op(OP_MAC, BASE_ADJ, 2, 1, BASE_BPA, 3, 1, BASE_TG, 2, 2, 3),
    ew_op(OP_DIV, BASE_TG, 1, BASE_DET, 0, BASE_G, 6),
    mm_op(OP_MAC, BASE_APB, 2, 1, BASE_G, 3, 1, BASE_CORR, 3, 2, 3),
    ew_op(OP_ADD, BASE_Q, 1, BASE_APA, 1, BASE_PA, 9),
    ew_op(OP_SUB, BASE_PA, 1, BASE_CORR, 1, BASE_PN, 9),
    ew_op(OP_CMP, BASE_PN, 1, BASE_P, 1, BASE_P, 9),
    ctl_op(OP_NEXT, PC_FIN),
    ew_op(OP_ADD, BASE_PN, 1, ZERO_ADDR, 0, BASE_P, 9),
    ctl_op(OP_JMP, PC_LOOP),
    ew_op(OP_ADD, BASE_PN, 1, ZERO_ADDR, 0, BASE_P, 9),
    mm_op(OP_MAC, BASE_P, 3, 1, BASE_A, 3, 1, BASE_PA, 3, 3, 3),
    mm_op(OP_MAC, BASE_P, 3, 1, BASE_B, 2, 1, BASE_PB, 3, 3, 2),
    mm_op(OP_MAC, BASE_B, 1, 2, BASE_PB, 2, 1, BASE_S, 2, 3, 2),
    ew_op(OP_ADD, BASE_R, 1, BASE_S, 1, BASE_S, 4),
    mm_op(OP_MAC, BASE_B, 1, 2, BASE_PA, 3, 1, BASE_BPA, 2, 3, 3),
    mm_op(OP_MAC, BASE_A, 1, 3, BASE_PA, 3, 1, BASE_APA, 3, 3, 3),
    mm_op(OP_MAC, BASE_A, 1, 3, BASE_PB, 2, 1, BASE_APB, 3, 3, 2),
    mm_op(OP_MAC, BASE_S, 0, 0, BASE_S + 7'd3, 0, 0, BASE_T0, 1, 1, 1),
    mm_op(OP_MAC, BASE_S + 7'd1, 0, 0, BASE_S + 7'd2, 0, 0, BASE_T1, 1, 1, 1),
    ew_op(OP_SUB, BASE_T0, 0, BASE_T1, 0, BASE_DET, 1),
    ew_op(OP_ADD, BASE_S + 7'd3, 0, ZERO_ADDR, 0, BASE_ADJ, 1),
    ew_op(OP_SUB, ZERO_ADDR, 0, BASE_S + 7'd1, 0, BASE_ADJ + 7'd1, 1),
    ew_op(OP_SUB, ZERO_ADDR, 0, BASE_S + 7'd2, 0, BASE_ADJ + 7'd2, 1),
    ew_op(OP_ADD, BASE_S, 0, ZERO_ADDR, 0, BASE_ADJ + 7'd3, 1),
    mm_op(OP_MAC, BASE_ADJ, 2, 1, BASE_BPA, 3, 1, BASE_TG, 2, 2, 3),
    ew_op(OP_DIV, BASE_TG, 1, BASE_DET, 0, BASE_G, 6),
    ew_op(OP_SUB, ZERO_ADDR, 0, BASE_G, 1, BASE_PA, 6),
    ew_op(OP_SUB, BASE_X, 1, BASE_REF, 1, BASE_PB, 3),
    mm_op(OP_MAC, BASE_PA, 3, 1, BASE_PB, 1, 0, BASE_U, 2, 3, 1),
    ctl_op(OP_DONE, PC_FIN)
  };

endpackage

[design/lqrg_ram.sv]
module lqrg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[design/lqrg_alu.sv]
module lqrg_alu import lqrg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_RND, A_ACC, A_DIV, A_DFIN} alu_state_e;

  alu_state_e    state_q;
  logic [6:0]    cnt_q;
  logic          neg_q;
  logic [W-1:0]  ma_q;
  logic [W-1:0]  mb_q;
  logic [2*W-1:0] prod_q;
  fx_t           acc_q;
  fx_t           rnd_q;
  logic [W:0]    rem_q;
  logic [QW-1:0] quo_q;
  logic [QW-1:0] num_q;
  fx_t           res_q;
  logic          done_q;
  logic          dzero_q;

  logic [23:0]    pa_sel;
  logic [23:0]    pb_sel;
  logic [47:0]    pp;
  logic [2*W-1:0] pp_sh;
  logic [2*W-1:0] rnd_sum;
  logic [W:0]     rem_sh;
  logic           rem_ge;
  logic [W:0]     half;
  logic [QW:0]    q_round;
  logic [W-1:0]   req_mb;
  logic           div_zero;
  logic           fast_done;

  // one 24x24 partial product per cycle
  assign pa_sel  = cnt_q[0] ? ma_q[47:24] : ma_q[23:0];
  assign pb_sel  = cnt_q[1] ? mb_q[47:24] : mb_q[23:0];
  assign pp      = pa_sel * pb_sel;
  assign rnd_sum = prod_q + ((2*W)'(1) << (FRAC - 1));
  assign rem_sh  = {rem_q[W-1:0], num_q[QW-1]};
  assign rem_ge  = rem_sh >= {1'b0, mb_q};
  assign half    = {1'b0, mb_q} - rem_q;
  assign q_round = {1'b0, quo_q} + (QW+1)'(rem_q >= half);
  assign req_mb  = mag(req_i.b);

  // add, subtract and divide by zero finish without leaving idle
  assign div_zero  = req_i.start && (req_i.kind == AK_DIV) && (req_mb == '0);
  assign fast_done = req_i.start && ((req_i.kind == AK_ADD) || (req_i.kind == AK_SUB) ||
                                     div_zero);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pp_sh = {48'b0, pp};
      2'd3:    pp_sh = {pp, 48'b0};
      default: pp_sh = {24'b0, pp, 24'b0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      dzero_q <= 1'b0;
    end else begin
      done_q  <= ((state_q == A_IDLE) && fast_done) || (state_q == A_ACC) ||
                 (state_q == A_DFIN);
      dzero_q <= (state_q == A_IDLE) && div_zero;
      case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            neg_q <= req_i.a[W-1] ^ req_i.b[W-1];
            ma_q  <= mag(req_i.a);
            mb_q  <= req_mb;
            acc_q <= req_i.acc;
            cnt_q <= '0;
            case (req_i.kind)
              AK_ADD: begin
                res_q <= sat_add(req_i.a, req_i.b);
              end
              AK_SUB: begin
                res_q <= sat_sub(req_i.a, req_i.b);
              end
              AK_DIV: begin
                if (req_mb == '0) begin
                  res_q <= '0;
                end else begin
                  num_q   <= {mag(req_i.a), {FRAC{1'b0}}};
                  rem_q   <= '0;
                  quo_q   <= '0;
                  state_q <= A_DIV;
                end
              end
              default: begin
                prod_q  <= '0;
                state_q <= A_MUL;
              end
            endcase
          end
        end
        A_MUL: begin
          prod_q <= prod_q + pp_sh;
          cnt_q  <= cnt_q + 7'd1;
          if (cnt_q[1:0] == 2'd3) state_q <= A_RND;
        end
        A_RND: begin
          rnd_q   <= fin(neg_q, {1'b0, rnd_sum[2*W-1:FRAC]});
          state_q <= A_ACC;
        end
        A_ACC: begin
          res_q   <= sat_add(acc_q, rnd_q);
          state_q <= A_IDLE;
        end
        A_DIV: begin
          // restoring division, one quotient bit per cycle
          num_q <= {num_q[QW-2:0], 1'b0};
          quo_q <= {quo_q[QW-2:0], rem_ge};
          rem_q <= rem_ge ? (rem_sh - {1'b0, mb_q}) : rem_sh;
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(QW - 1)) state_q <= A_DFIN;
        end
        A_DFIN: begin
          res_q   <= fin(neg_q, q_round);
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.busy  = (state_q != A_IDLE);
  assign rsp_o.dzero = dzero_q;
  assign rsp_o.res   = res_q;

endmodule

[design/lqr_riccati_gain_solver_unit.sv]
// Discrete LQR gain solver. A load item (tuser 0) writes one element of A, B, Q, R, the
// state or the reference into scratch memory. A run item (tuser 1) iterates the Riccati
// recursion from P = Q until every |P'-P| is below eps_threshold or iteration_limit
// passes are done, then forms K from the last P' and returns u = -K(x - ref) with the
// singular and converged flags as one result item. All arithmetic but the convergence
// compare goes through a single shared multiply/divide unit (four 24x24 partial products
// per multiply, one quotient bit per cycle for divides) under a small microcoded
// sequencer; the input is not ready while a run is in progress.
module lqr_riccati_gain_solver_unit import lqrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // index[5:0], value[53:6], zero[55:54]
  input  logic [0:0]  s_axis_tuser,   // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // speed_command[47:0], steer_command[95:48]
  output logic [1:0]  m_axis_tuser,   // singular[0], converged[1]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [46:0] cfg_data_i
);

  typedef enum logic [2:0] {T_IDLE, T_OP, T_RD, T_LAT, T_EXE, T_WR, T_DONE} top_state_e;

  localparam logic [0:0] REG_LIMIT = 1'b0;
  localparam logic [0:0] REG_EPS   = 1'b1;

  top_state_e     state_q;
  logic [PCW-1:0] pc_q;
  logic [1:0]     i_q;
  logic [3:0]     j_q;
  logic [1:0]     k_q;
  fx_t            acc_q;
  fx_t            res_q;
  logic           za_q;
  logic           zb_q;
  logic [15:0]    it_q;
  logic [15:0]    limit_q;
  logic [46:0]    eps_q;
  logic           small_q;
  logic           sing_q;
  logic           conv_q;
  fx_t            u_q [2];
  logic           out_valid_q;
  fx_t            out_speed_q;
  fx_t            out_steer_q;
  logic           out_sing_q;
  logic           out_conv_q;

  op_t           op;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] addr_z;
  logic [W-1:0]  rd_a;
  logic [W-1:0]  rd_b;
  fx_t           opa;
  fx_t           opb;
  logic          in_acc;
  logic          load_we;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic [5:0]    in_index;
  logic signed [W:0] diff;
  logic [W:0]    diff_mag;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;
  alu_kind_e     alu_kind;
  logic          out_free;

  function automatic logic [AW-1:0] addr_of(logic [AW-1:0] base, logic [1:0] si,
                                            logic [1:0] sj, logic [1:0] sk,
                                            logic [1:0] i, logic [3:0] j, logic [1:0] k);
    return base + AW'(i * si) + AW'(j * sj) + AW'(k * sk);
  endfunction

  assign op       = PROG[pc_q];
  assign addr_a   = addr_of(op.a_base, op.a_si, op.a_sj, op.a_sk, i_q, j_q, k_q);
  assign addr_b   = addr_of(op.b_base, op.b_si, op.b_sj, op.b_sk, i_q, j_q, k_q);
  assign addr_z   = op.z_base + AW'(i_q * op.cols) + AW'(j_q);
  assign in_index = s_axis_tdata[5:0];

  assign s_axis_tready = (state_q == T_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_we       = in_acc && !s_axis_tuser[0] && (in_index < 6'(SLOT_END));
  assign ram_we        = load_we || (state_q == T_WR && op.kind != OP_CMP);
  assign ram_waddr     = (state_q == T_IDLE) ? {1'b0, in_index} : addr_z;
  assign ram_wdata     = (state_q == T_IDLE) ? s_axis_tdata[53:6] : res_q;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // the spare top address reads as zero and is never written
  assign opa      = za_q ? '0 : fx_t'(rd_a);
  assign opb      = zb_q ? '0 : fx_t'(rd_b);
  assign diff     = {opa[W-1], opa} - {opb[W-1], opb};
  assign diff_mag = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);

  always_comb begin
    case (op.kind)
      OP_ADD:  alu_kind = AK_ADD;
      OP_SUB:  alu_kind = AK_SUB;
      OP_DIV:  alu_kind = AK_DIV;
      default: alu_kind = AK_MAC;
    endcase
  end

  assign alu_req.start = (state_q == T_LAT) && (op.kind != OP_CMP);
  assign alu_req.kind  = alu_kind;
  assign alu_req.a     = opa;
  assign alu_req.b     = opb;
  assign alu_req.acc   = acc_q;

  lqrg_ram #(
    .WIDTH(W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  lqrg_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      pc_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      it_q        <= '0;
      limit_q     <= 16'd100;
      eps_q       <= 47'd16777;
      small_q     <= 1'b0;
      sing_q      <= 1'b0;
      conv_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state_q != T_DONE) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_LIMIT: limit_q <= cfg_data_i[15:0];
          REG_EPS:   eps_q   <= cfg_data_i;
          default:   eps_q   <= cfg_data_i;
        endcase
      end
      case (state_q)
        T_IDLE: begin
          if (in_acc && s_axis_tuser[0]) begin
            pc_q    <= '0;
            it_q    <= '0;
            sing_q  <= 1'b0;
            conv_q  <= 1'b0;
            state_q <= T_OP;
          end
        end
        T_OP: begin
          i_q   <= '0;
          j_q   <= '0;
          k_q   <= '0;
          acc_q <= '0;
          case (op.kind)
            OP_CHK: begin
              small_q <= 1'b1;
              pc_q    <= (it_q >= limit_q) ? op.target : pc_q + 6'd1;
            end
            OP_NEXT: begin
              it_q <= it_q + 16'd1;
              if (small_q) begin
                conv_q <= 1'b1;
                pc_q   <= op.target;
              end else begin
                pc_q <= pc_q + 6'd1;
              end
            end
            OP_JMP:  pc_q    <= op.target;
            OP_DONE: state_q <= T_DONE;
            default: state_q <= T_RD;
          endcase
        end
        T_RD: begin
          za_q    <= (addr_a == ZERO_ADDR);
          zb_q    <= (addr_b == ZERO_ADDR);
          state_q <= T_LAT;
        end
        T_LAT: begin
          if (op.kind == OP_CMP) begin
            if (diff_mag >= {2'b0, eps_q}) small_q <= 1'b0;
            state_q <= T_WR;
          end else begin
            state_q <= T_EXE;
          end
        end
        T_EXE: begin
          if (alu_rsp.done) begin
            if (alu_rsp.dzero) sing_q <= 1'b1;
            if (op.kind == OP_MAC && k_q != op.inner - 2'd1) begin
              acc_q   <= alu_rsp.res;
              k_q     <= k_q + 2'd1;
              state_q <= T_RD;
            end else begin
              res_q   <= alu_rsp.res;
              state_q <= T_WR;
            end
          end
        end
        T_WR: begin
          if (op.z_base == BASE_U) u_q[i_q[0]] <= res_q;
          k_q   <= '0;
          acc_q <= '0;
          if (j_q == op.cols - 4'd1) begin
            j_q <= '0;
            if (i_q == op.rows - 2'd1) begin
              pc_q    <= pc_q + 6'd1;
              state_q <= T_OP;
            end else begin
              i_q     <= i_q + 2'd1;
              state_q <= T_RD;
            end
          end else begin
            j_q     <= j_q + 4'd1;
            state_q <= T_RD;
          end
        end
        T_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_speed_q <= u_q[0];
            out_steer_q <= u_q[1];
            out_sing_q  <= sing_q;
            out_conv_q  <= conv_q;
            state_q     <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_steer_q, out_speed_q};
  assign m_axis_tuser  = {out_conv_q, out_sing_q};

  a_alu_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != T_IDLE) |-> (it_q <= limit_q))
    else $error("iteration count passed the limit");

  a_conv_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(conv_q) |-> $past(small_q))
    else $error("converged without a small difference pass");

endmodule

[test/lqr_riccati_gain_solver_unit_test.sv]
module lqr_riccati_gain_solver_unit_test;
  import lqrg_pkg::*;

  localparam int CFG_ITER_LIMIT = 0;
  localparam int CFG_EPS        = 1;
  localparam bit CMD_LOAD       = 1'b0;
  localparam bit CMD_RUN        = 1'b1;
  localparam fx_t ONE           = 48'sd16777216;

  typedef fx_t mat_t [9];

  typedef struct {
    fx_t speed;
    fx_t steer;
    bit  singular;
    bit  converged;
  } ctl_out_t;

  typedef struct {
    bit       cmd;
    bit [5:0] idx;
    fx_t      val;
    bit       typed;
    ctl_out_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // index[5:0], value[53:6], zero[55:54]
  logic [0:0]  s_axis_tuser = '0;   // cmd[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;        // speed_command[47:0], steer_command[95:48]
  logic [1:0]  m_axis_tuser;        // singular[0], converged[1]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [46:0] cfg_data_i = '0;

  lqr_riccati_gain_solver_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block's stores and registers
  mat_t   sys_m, in_m, q_w, r_w, pose_m;
  int     iter_lim;
  longint eps_bound;

  ctl_out_t ctl_q[$];
  int       fail_cnt;
  bit       quiet;

  function automatic fx_t sat_word(longint x);
    if (x > longint'(FX_MAX)) return FX_MAX;
    if (x < longint'(FX_MIN)) return FX_MIN;
    return fx_t'(x);
  endfunction

  function automatic fx_t fx_add(fx_t a, fx_t b);
    return sat_word(longint'(a) + longint'(b));
  endfunction

  function automatic fx_t fx_sub(fx_t a, fx_t b);
    return sat_word(longint'(a) - longint'(b));
  endfunction

  function automatic logic [127:0] fx_mag(fx_t a);
    longint v;
    v = longint'(a);
    return 128'(v < 0 ? -v : v);
  endfunction

  function automatic fx_t signed_cap(bit neg, logic [127:0] m);
    logic [127:0] cap;
    logic [127:0] v;
    cap = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    v = (m > cap) ? cap : m;
    return neg ? fx_t'(-v[47:0]) : fx_t'(v[47:0]);
  endfunction

  function automatic fx_t fx_mul(fx_t a, fx_t b);
    logic [127:0] p;
    p = (fx_mag(a) * fx_mag(b) + (128'd1 << 23)) >> 24;
    return signed_cap((a < 0) != (b < 0), p);
  endfunction

  function automatic fx_t fx_div(fx_t n, fx_t d);
    logic [127:0] num, md, q, r;
    md = fx_mag(d);
    if (md == 0) return '0;
    num = fx_mag(n) << 24;
    q = num / md;
    r = num % md;
    if (r >= md - r) q = q + 1;
    return signed_cap((n < 0) != (d < 0), q);
  endfunction

  function automatic void mat_mul(input mat_t x, input int xr, input int xc,
                                  input mat_t y, input int yr, input int yc,
                                  input int rows, input int inner, input int cols,
                                  output mat_t z);
    fx_t acc;
    z = '{default: '0};
    for (int i = 0; i < rows; i++)
      for (int j = 0; j < cols; j++) begin
        acc = '0;
        for (int k = 0; k < inner; k++)
          acc = fx_add(acc, fx_mul(x[i*xr + k*xc], y[k*yr + j*yc]));
        z[i*cols + j] = acc;
      end
  endfunction

  // gain (R+B'PB)^-1 B'PA with A'PA and A'PB; returns 1 on a zero determinant
  function automatic bit gain_terms(input mat_t p, output mat_t g, output mat_t apa,
                                    output mat_t apb);
    mat_t pa, pb, bpa, s, adj;
    fx_t  det, acc;
    mat_mul(p, 3, 1, sys_m, 3, 1, 3, 3, 3, pa);
    mat_mul(p, 3, 1, in_m, 2, 1, 3, 3, 2, pb);
    mat_mul(in_m, 1, 2, pb, 2, 1, 2, 3, 2, s);
    for (int i = 0; i < 4; i++) s[i] = fx_add(r_w[i], s[i]);
    mat_mul(in_m, 1, 2, pa, 3, 1, 2, 3, 3, bpa);
    mat_mul(sys_m, 1, 3, pa, 3, 1, 3, 3, 3, apa);
    mat_mul(sys_m, 1, 3, pb, 2, 1, 3, 3, 2, apb);
    det = fx_sub(fx_mul(s[0], s[3]), fx_mul(s[1], s[2]));
    adj = '{default: '0};
    adj[0] = s[3];
    adj[1] = fx_sub('0, s[1]);
    adj[2] = fx_sub('0, s[2]);
    adj[3] = s[0];
    g = '{default: '0};
    if (det == 0) return 1'b1;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 3; j++) begin
        acc = '0;
        for (int k = 0; k < 2; k++)
          acc = fx_add(acc, fx_mul(adj[i*2 + k], bpa[k*3 + j]));
        g[i*3 + j] = fx_div(acc, det);
      end
    return 1'b0;
  endfunction

  function automatic ctl_out_t solve_control();
    mat_t     p, pn, g, apa, apb, corr;
    fx_t      x [3];
    fx_t      acc;
    fx_t      u [2];
    longint   diff;
    bit       small_step;
    ctl_out_t r;
    r = '{default: 0};
    p = q_w;
    pn = q_w;
    for (int it = 0; it < iter_lim; it++) begin
      small_step = 1'b1;
      if (gain_terms(p, g, apa, apb)) r.singular = 1'b1;
      mat_mul(apb, 2, 1, g, 3, 1, 3, 2, 3, corr);
      for (int i = 0; i < 9; i++) begin
        pn[i] = fx_sub(fx_add(q_w[i], apa[i]), corr[i]);
        diff = longint'(pn[i]) - longint'(p[i]);
        if (diff < 0) diff = -diff;
        if (diff >= eps_bound) small_step = 1'b0;
      end
      if (small_step) begin
        r.converged = 1'b1;
        break;
      end
      p = pn;
    end
    if (gain_terms(pn, g, apa, apb)) r.singular = 1'b1;
    for (int j = 0; j < 3; j++) x[j] = fx_sub(pose_m[j], pose_m[3 + j]);
    for (int i = 0; i < 2; i++) begin
      acc = '0;
      for (int j = 0; j < 3; j++) acc = fx_add(acc, fx_mul(fx_sub('0, g[i*3 + j]), x[j]));
      u[i] = acc;
    end
    r.speed = u[0];
    r.steer = u[1];
    return r;
  endfunction

  function automatic void store_element(bit [5:0] idx, fx_t v);
    if (idx < 9) sys_m[idx] = v;
    else if (idx < 15) in_m[idx - 9] = v;
    else if (idx < 24) q_w[idx - 15] = v;
    else if (idx < 28) r_w[idx - 24] = v;
    else if (idx < 34) pose_m[idx - 28] = v;
  endfunction

  function automatic bit gap_now();
    return !quiet && ($urandom_range(99) < 20);
  endfunction

  task automatic send_item(stim_row_t row);
    while (gap_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, row.val, row.idx};
    s_axis_tuser  <= row.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    if (row.cmd == CMD_LOAD) store_element(row.idx, row.val);
    else if (row.typed) ctl_q.push_back(row.res);
    else ctl_q.push_back(solve_control());
  endtask

  // loads leave no result, so keep clocking the block after the queue empties
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (ctl_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, logic [46:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 1'(idx);
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_ITER_LIMIT) iter_lim = int'(data[15:0]);
    else eps_bound = longint'(data);
    @(posedge clk_i);
  endtask

  function automatic fx_t rand_value();
    if ($urandom_range(3) == 0) return fx_t'({$urandom(), $urandom()});
    return fx_t'($signed($urandom_range(32'h7FF_FFFF)) - 32'sh400_0000);
  endfunction

  function automatic stim_row_t load_row(int idx, fx_t v);
    stim_row_t r;
    r = '{cmd: CMD_LOAD, idx: 6'(idx), val: v, typed: 1'b0, res: '{default: 0}};
    return r;
  endfunction

  function automatic stim_row_t run_row(bit typed, bit sing);
    stim_row_t r;
    r = '{cmd: CMD_RUN, idx: 6'd63, val: FX_MIN, typed: typed,
          res: '{speed: '0, steer: '0, singular: sing, converged: 1'b1}};
    return r;
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 20);
  end

  always @(posedge clk_i) begin
    ctl_out_t want;
    ctl_out_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{speed: fx_t'(m_axis_tdata[47:0]), steer: fx_t'(m_axis_tdata[95:48]),
              singular: m_axis_tuser[0], converged: m_axis_tuser[1]};
      if (ctl_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected item: speed %0d steer %0d", got.speed, got.steer);
      end else begin
        want = ctl_q.pop_front();
        if (got.speed !== want.speed || got.steer !== want.steer ||
            got.singular !== want.singular || got.converged !== want.converged) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: speed %0d/%0d steer %0d/%0d singular %0d/%0d converged %0d/%0d",
                     want.speed, got.speed, want.steer, got.steer,
                     want.singular, got.singular, want.converged, got.converged);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    stim_row_t tbl[$];
    int        items;
    int        results;
    int        ep;
    int        nload;
    logic [46:0] eps_v;

    sys_m = '{default: '0};
    in_m = '{default: '0};
    q_w = '{default: '0};
    r_w = '{default: '0};
    pose_m = '{default: '0};
    iter_lim = 100;
    eps_bound = 16777;
    fail_cnt = 0;
    quiet = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A and B zero: P stays at Q, gain is zero, so u is zero and the first pass converges
    for (int i = 0; i < 15; i++) tbl.push_back(load_row(i, '0));
    tbl.push_back(load_row(15, FX_MAX));
    tbl.push_back(load_row(16, FX_MIN));
    tbl.push_back(load_row(17, ONE));
    tbl.push_back(load_row(18, -ONE));
    for (int i = 19; i < 24; i++) tbl.push_back(load_row(i, fx_t'(i)));
    tbl.push_back(load_row(24, ONE));
    tbl.push_back(load_row(25, '0));
    tbl.push_back(load_row(26, '0));
    tbl.push_back(load_row(27, ONE));
    tbl.push_back(load_row(28, FX_MAX));
    tbl.push_back(load_row(29, FX_MIN));
    tbl.push_back(load_row(30, '0));
    tbl.push_back(load_row(31, FX_MIN));
    tbl.push_back(load_row(32, FX_MAX));
    tbl.push_back(load_row(33, -ONE));
    // slots past the reference are ignored
    tbl.push_back(load_row(34, FX_MAX));
    tbl.push_back(load_row(63, FX_MIN));
    tbl.push_back(run_row(1'b1, 1'b0));
    // zero R gives a zero determinant
    tbl.push_back(load_row(24, '0));
    tbl.push_back(load_row(27, '0));
    tbl.push_back(run_row(1'b1, 1'b1));
    tbl.push_back(load_row(24, ONE + ONE));
    tbl.push_back(load_row(27, ONE));
    tbl.push_back(load_row(9, ONE));
    tbl.push_back(load_row(0, ONE >>> 1));
    tbl.push_back(run_row(1'b0, 1'b0));
    foreach (tbl[i]) send_item(tbl[i]);
    items = tbl.size();
    results = 3;
    drain();

    ep = 0;
    while (items < 600 || results < 40) begin
      case (ep)
        0: begin
          write_reg(CFG_ITER_LIMIT, {31'h7FFF_FFFF, 16'd0});
          write_reg(CFG_EPS, 47'h7FFF_FFFF_FFFF);
        end
        1: write_reg(CFG_ITER_LIMIT, {31'd0, 16'hFFFF});
        2: begin
          write_reg(CFG_ITER_LIMIT, 47'd1);
          write_reg(CFG_EPS, 47'd0);
        end
        3: begin
          write_reg(CFG_ITER_LIMIT, {31'($urandom()), 16'd2});
          write_reg(CFG_EPS, 47'd1);
        end
        default: begin
          write_reg(CFG_ITER_LIMIT,
                    {31'($urandom()),
                     16'($urandom_range(9) == 0 ? 3 : $urandom_range(2, 1))});
          eps_v = 47'({$urandom(), $urandom()});
          if ($urandom_range(1)) eps_v = eps_v >> $urandom_range(46);
          write_reg(CFG_EPS, eps_v);
        end
      endcase
      quiet = (ep >= 10 && ep < 20);
      // with a large limit the first pass must converge, so keep every element small
      nload = (ep == 1) ? 34 : $urandom_range(12, 1);
      for (int n = 0; n < nload; n++) begin
        if (ep == 1)
          send_item(load_row(n, fx_t'($signed($urandom_range(32'hFF_FFFF)) - 32'sh80_0000)));
        else if ($urandom_range(9) == 0)
          send_item(load_row($urandom_range(63), rand_value()));
        else
          send_item(load_row($urandom_range(33), rand_value()));
        items++;
      end
      tbl[0] = run_row(1'b0, 1'b0);
      tbl[0].idx = 6'($urandom());
      tbl[0].val = rand_value();
      send_item(tbl[0]);
      items++;
      results++;
      // the sender waits for the result before the next settings
      drain();
      ep++;
    end
    quiet = 1'b0;
    drain();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && ctl_q.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[lqr_riccati_gain_solver_unit.f]
design/lqrg_pkg.sv
design/lqrg_ram.sv
design/lqrg_alu.sv
design/lqr_riccati_gain_solver_unit.sv
test/lqr_riccati_gain_solver_unit_test.sv
